// ===== rtl/system_register_write_and_page_map_assert.svh =====
// ---------------------------------------------------------------------------
// System register write block: assertion macros
// Shared property macros for the clocked checks of this block.
// ---------------------------------------------------------------------------
`ifndef SYSTEM_REGISTER_WRITE_AND_PAGE_MAP_ASSERT_SVH
`define SYSTEM_REGISTER_WRITE_AND_PAGE_MAP_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define SRWPM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define SRWPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/srwpm_pkg.sv =====
// ---------------------------------------------------------------------------
// System register write block: shared package
// Item types, register addresses, write masks and the page code table.
// ---------------------------------------------------------------------------
package srwpm_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_ROM_PRESENT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_LOOPBACK = 1'b1;

    // Word addresses of the system registers (bit 0 cleared).
    localparam logic [15:0] ADDR_KBD    = 16'o177660;
    localparam logic [15:0] ADDR_VIDEO  = 16'o177662;
    localparam logic [15:0] ADDR_SCROLL = 16'o177664;
    localparam logic [15:0] ADDR_PORT   = 16'o177714;
    localparam logic [15:0] ADDR_SYS    = 16'o177716;

    localparam logic [15:0] MASK_VIDEO  = 16'o147400;
    localparam logic [9:0]  MASK_SCROLL = 10'o1377;
    localparam logic [15:0] MASK_PAGE   = 16'o077433;
    localparam logic [12:0] MASK_TAPE   = 13'o10344;

    localparam int SYS_PAGE_SEL_BIT = 11;
    localparam int KBD_MASK_BIT     = 6;

    localparam logic [2:0] SCREEN_PAGE_MAIN = 3'd5;
    localparam logic [2:0] SCREEN_PAGE_ALT  = 3'd6;
    localparam logic [3:0] WND1_PAGE_MAX    = 4'd11;

    typedef struct packed {
        logic [15:0] address;
        logic [15:0] data;
        logic        byte_op;
    } wr_item_t;

    typedef struct packed {
        logic        kbd_int_mask;
        logic [15:0] video_ctrl;
        logic [9:0]  scroll;
        logic [15:0] port_out;
        logic [15:0] port_in;
        logic [12:0] tape;
        logic [15:0] page;
        logic        write_latch;
    } sys_state_t;

    typedef struct packed {
        logic [2:0] wnd0_page;
        logic [3:0] wnd1_page;
        logic [3:0] wnd1_readable;
    } page_map_t;

    typedef struct packed {
        logic        handled;
        logic        kbd_int_mask;
        logic [15:0] video_ctrl;
        logic [2:0]  screen_page;
        logic [9:0]  scroll;
        logic [15:0] port_out;
        logic [15:0] port_in;
        logic [12:0] tape_bits;
        logic [2:0]  wnd0_page;
        logic [3:0]  wnd1_page;
        logic [3:0]  wnd1_readable;
        logic        write_latch;
    } rsp_item_t;

    // Logical page number in the page register to physical RAM page.
    function automatic logic [2:0] page_code(input logic [2:0] sel);
        logic [2:0] code;
        case (sel)
            3'd0:    code = 3'd1;
            3'd1:    code = 3'd5;
            3'd2:    code = 3'd2;
            3'd3:    code = 3'd3;
            3'd4:    code = 3'd4;
            3'd5:    code = 3'd7;
            3'd6:    code = 3'd0;
            3'd7:    code = 3'd6;
            default: code = 3'd1;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/srwpm_wr_if.sv =====
// ---------------------------------------------------------------------------
// System register write block: bus write channel
// Valid/ready channel that carries one bus write per transfer.
// ---------------------------------------------------------------------------
interface srwpm_wr_if;
    logic        valid;
    logic        ready;
    logic [15:0] address;
    logic [15:0] data;
    logic        byte_op;

    modport source (output valid, output address, output data, output byte_op,
                    input ready);
    modport sink   (input valid, input address, input data, input byte_op,
                    output ready);
endinterface

// ===== rtl/srwpm_rsp_if.sv =====
// ---------------------------------------------------------------------------
// System register write block: result channel
// Valid/ready channel that carries register contents and the page map.
// ---------------------------------------------------------------------------
interface srwpm_rsp_if;
    logic        valid;
    logic        ready;
    logic        handled;
    logic        kbd_int_mask;
    logic [15:0] video_ctrl;
    logic [2:0]  screen_page;
    logic [9:0]  scroll;
    logic [15:0] port_out;
    logic [15:0] port_in;
    logic [12:0] tape_bits;
    logic [2:0]  wnd0_page;
    logic [3:0]  wnd1_page;
    logic [3:0]  wnd1_readable;
    logic        write_latch;

    modport source (output valid, output handled, output kbd_int_mask,
                    output video_ctrl, output screen_page, output scroll,
                    output port_out, output port_in, output tape_bits,
                    output wnd0_page, output wnd1_page, output wnd1_readable,
                    output write_latch, input ready);
    modport sink   (input valid, input handled, input kbd_int_mask,
                    input video_ctrl, input screen_page, input scroll,
                    input port_out, input port_in, input tape_bits,
                    input wnd0_page, input wnd1_page, input wnd1_readable,
                    input write_latch, output ready);
endinterface

// ===== rtl/srwpm_in_stage.sv =====
// ---------------------------------------------------------------------------
// System register write block: input register
// Captures one bus write and holds it until the result stage takes it.
// ---------------------------------------------------------------------------
module srwpm_in_stage
    import srwpm_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    srwpm_wr_if.sink       wr,
    input  logic           advance,
    output logic           item_valid,
    output wr_item_t       item
);

    logic     valid_reg;
    logic     valid_next;
    wr_item_t item_reg;
    logic     load;

    // The slot may refill in the same cycle that its item moves on.
    assign wr.ready = !valid_reg || advance;
    assign load     = wr.valid && wr.ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= '{address: wr.address, data: wr.data, byte_op: wr.byte_op};
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/srwpm_sys_regs.sv =====
// ---------------------------------------------------------------------------
// System register write block: register file
// Address decode, byte lane merge and masked update of the system registers.
// ---------------------------------------------------------------------------
module srwpm_sys_regs
    import srwpm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  wr_item_t   item,
    input  logic       port_loopback,
    output logic       handled,
    output sys_state_t state_next
);

    sys_state_t  state_reg;
    logic [15:0] word_addr;
    logic [15:0] lane_val;
    logic [15:0] scroll_src;

    assign word_addr  = {item.address[15:1], 1'b0};
    assign scroll_src = item.byte_op ? {8'h00, item.data[7:0]} : item.data;

    // A byte write lands in the lane picked by address bit 0; the other lane is zero.
    always_comb
    begin
        if (!item.byte_op)
        begin
            lane_val = item.data;
        end
        else if (item.address[0])
        begin
            lane_val = {item.data[7:0], 8'h00};
        end
        else
        begin
            lane_val = {8'h00, item.data[7:0]};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        handled    = 1'b1;
        case (word_addr)
            ADDR_KBD:
            begin
                // A byte write to the high byte leaves the mask bit alone.
                if (!(item.byte_op && item.address[0]))
                begin
                    state_next.kbd_int_mask = item.data[KBD_MASK_BIT];
                end
            end
            ADDR_VIDEO:
            begin
                state_next.video_ctrl = (state_reg.video_ctrl & ~MASK_VIDEO)
                                      | (lane_val & MASK_VIDEO);
            end
            ADDR_SCROLL:
            begin
                state_next.scroll = (state_reg.scroll & ~MASK_SCROLL)
                                  | (scroll_src[9:0] & MASK_SCROLL);
            end
            ADDR_PORT:
            begin
                state_next.port_out = lane_val;
                if (port_loopback)
                begin
                    state_next.port_in = lane_val;
                end
            end
            ADDR_SYS:
            begin
                if (lane_val[SYS_PAGE_SEL_BIT])
                begin
                    state_next.page = (state_reg.page & ~MASK_PAGE) | (lane_val & MASK_PAGE);
                end
                else
                begin
                    state_next.tape = (state_reg.tape & ~MASK_TAPE)
                                    | (lane_val[12:0] & MASK_TAPE);
                end
                state_next.write_latch = 1'b1;
            end
            default:
            begin
                handled = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/srwpm_page_dec.sv =====
// ---------------------------------------------------------------------------
// System register write block: page decoder
// Maps the page register onto window 0 and window 1 pages and bank access.
// ---------------------------------------------------------------------------
module srwpm_page_dec
    import srwpm_pkg::*;
(
    input  logic [15:0]           page,
    input  logic [CFG_DATA_W-1:0] rom_present,
    output page_map_t             map
);

    logic       rom_sel;
    logic [1:0] rom_idx;

    // ROM select bits in falling priority: bit 0, bit 1, bit 3, bit 4.
    always_comb
    begin
        rom_sel = 1'b1;
        if (page[0])
        begin
            rom_idx = 2'd0;
        end
        else if (page[1])
        begin
            rom_idx = 2'd1;
        end
        else if (page[3])
        begin
            rom_idx = 2'd2;
        end
        else if (page[4])
        begin
            rom_idx = 2'd3;
        end
        else
        begin
            rom_idx = 2'd0;
            rom_sel = 1'b0;
        end
    end

    always_comb
    begin
        map.wnd0_page = page_code(page[14:12]);
        if (rom_sel)
        begin
            map.wnd1_page     = {2'b10, rom_idx};
            map.wnd1_readable = {{2{rom_present[{rom_idx, 1'b1}]}},
                                 {2{rom_present[{rom_idx, 1'b0}]}}};
        end
        else
        begin
            map.wnd1_page     = {1'b0, page_code(page[10:8])};
            map.wnd1_readable = 4'hF;
        end
    end

endmodule

// ===== rtl/system_register_write_and_page_map.sv =====
// An accepted write passes through the input register and then the result register
// before its result transfer; the result register loads only while it is empty or being taken.
// Throughput: one write per cycle while results are taken; the input register refills
// as the result register is loaded, so a stalled result only holds the single input slot.
// Reset (rst_n, asynchronous, active low) clears every system register, the
// write latch, both configuration registers and all valid flags.
// ---------------------------------------------------------------------------
// System register write and page map
// Top level: configuration registers, result register and the pipeline glue.
// ---------------------------------------------------------------------------
`include "system_register_write_and_page_map_assert.svh"

module system_register_write_and_page_map
    import srwpm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    srwpm_wr_if.sink              wr,
    srwpm_rsp_if.source           rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [CFG_DATA_W-1:0] rom_present_reg;
    logic                  port_loopback_reg;
    logic                  out_valid_reg;
    rsp_item_t             rsp_reg;

    logic       item_valid;
    wr_item_t   item;
    logic       advance;
    logic       fire;
    logic       handled;
    sys_state_t state_next;
    page_map_t  map;

    assign advance = !out_valid_reg || rsp.ready;
    assign fire    = item_valid && advance;

    srwpm_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    srwpm_sys_regs u_sys_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .item          (item),
        .port_loopback (port_loopback_reg),
        .handled       (handled),
        .state_next    (state_next)
    );

    srwpm_page_dec u_page_dec (
        .page        (state_next.page),
        .rom_present (rom_present_reg),
        .map         (map)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_present_reg   <= '0;
            port_loopback_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROM_PRESENT:   rom_present_reg   <= cfg_wdata;
                CFG_PORT_LOOPBACK: port_loopback_reg <= cfg_wdata[0];
                default:           rom_present_reg   <= rom_present_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= item_valid;
        end
    end

    // The result shows the register contents after this write has landed.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_reg.handled       <= handled;
            rsp_reg.kbd_int_mask  <= state_next.kbd_int_mask;
            rsp_reg.video_ctrl    <= state_next.video_ctrl;
            rsp_reg.screen_page   <= state_next.video_ctrl[15] ? SCREEN_PAGE_ALT
                                                               : SCREEN_PAGE_MAIN;
            rsp_reg.scroll        <= state_next.scroll;
            rsp_reg.port_out      <= state_next.port_out;
            rsp_reg.port_in       <= state_next.port_in;
            rsp_reg.tape_bits     <= state_next.tape;
            rsp_reg.wnd0_page     <= map.wnd0_page;
            rsp_reg.wnd1_page     <= map.wnd1_page;
            rsp_reg.wnd1_readable <= map.wnd1_readable;
            rsp_reg.write_latch   <= state_next.write_latch;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.handled       = rsp_reg.handled;
    assign rsp.kbd_int_mask  = rsp_reg.kbd_int_mask;
    assign rsp.video_ctrl    = rsp_reg.video_ctrl;
    assign rsp.screen_page   = rsp_reg.screen_page;
    assign rsp.scroll        = rsp_reg.scroll;
    assign rsp.port_out      = rsp_reg.port_out;
    assign rsp.port_in       = rsp_reg.port_in;
    assign rsp.tape_bits     = rsp_reg.tape_bits;
    assign rsp.wnd0_page     = rsp_reg.wnd0_page;
    assign rsp.wnd1_page     = rsp_reg.wnd1_page;
    assign rsp.wnd1_readable = rsp_reg.wnd1_readable;
    assign rsp.write_latch   = rsp_reg.write_latch;

    // A held input item must not vanish while the result side is stalled.
    `SRWPM_ASSERT_NEXT(a_item_held, item_valid && !advance, item_valid,
        "input item lost while result stalled")
    // Once a result reports the write latch set, later results keep it set.
    `SRWPM_ASSERT_NEXT(a_latch_sticky, out_valid_reg && rsp_reg.write_latch,
        rsp_reg.write_latch, "write latch cleared by a write")
    // RAM in window 1 always leaves all four banks readable.
    `SRWPM_ASSERT_NOW(a_ram_readable, out_valid_reg && !rsp_reg.wnd1_page[3],
        rsp_reg.wnd1_readable == 4'hF, "RAM window 1 not fully readable")
    // Window 1 never decodes past the last ROM page.
    `SRWPM_ASSERT_NOW(a_wnd1_range, out_valid_reg, rsp_reg.wnd1_page <= WND1_PAGE_MAX,
        "window 1 page out of range")

endmodule

// ===== verif/tb.sv =====
// ---------------------------------------------------------------------------
// System register write and page map: testbench
// Drives bus writes into the block and checks every result transfer against
// an in-bench model of the system registers and the window page decode.
// ---------------------------------------------------------------------------
module tb;
    import srwpm_pkg::*;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int SEGMENTS         = 6;
    localparam int WRITES_PER_SEG   = 255;
    localparam int SETTLE_CYCLES    = 4;
    localparam logic [3:0] ROM_PAGE_FIRST = 4'd8;

    // Expected register view, computed from each accepted write and held in
    // arrival order until the matching result transfer shows up.
    class sys_reg_scoreboard;
        int         errors;
        rsp_item_t  reg_view_q[$];
        logic [7:0] rom_present;
        logic       port_loopback;
        logic       kbd_mask;
        logic [15:0] video;
        logic [9:0]  scroll;
        logic [15:0] port_out;
        logic [15:0] port_in;
        logic [12:0] tape;
        logic [15:0] page;
        logic        latch;
        logic [2:0]  phys_page[8];

        function new();
            errors        = 0;
            rom_present   = '0;
            port_loopback = 1'b0;
            kbd_mask      = 1'b0;
            video         = '0;
            scroll        = '0;
            port_out      = '0;
            port_in       = '0;
            tape          = '0;
            page          = '0;
            latch         = 1'b0;
            phys_page     = '{3'd1, 3'd5, 3'd2, 3'd3, 3'd4, 3'd7, 3'd0, 3'd6};
        endfunction

        function void set_config(logic [7:0] rom, logic loopback);
            rom_present   = rom;
            port_loopback = loopback;
        endfunction

        function int pending();
            return reg_view_q.size();
        endfunction

        function void note_write(wr_item_t w);
            rsp_item_t   r;
            logic [15:0] lane_val;
            logic [15:0] scroll_src;
            logic [1:0]  rom_sel;
            logic        has_rom;

            // Byte writes land in the lane picked by address bit 0.
            if (!w.byte_op)
                lane_val = w.data;
            else if (w.address[0])
                lane_val = {w.data[7:0], 8'h00};
            else
                lane_val = {8'h00, w.data[7:0]};

            r.handled = 1'b1;
            case ({w.address[15:1], 1'b0})
                ADDR_KBD:
                    // A high-byte write cannot reach the mask bit.
                    if (!(w.byte_op && w.address[0]))
                        kbd_mask = w.data[KBD_MASK_BIT];
                ADDR_VIDEO:
                    video = (video & ~MASK_VIDEO) | (lane_val & MASK_VIDEO);
                ADDR_SCROLL:
                begin
                    // Scroll byte writes always fill the low byte.
                    scroll_src = w.byte_op ? {8'h00, w.data[7:0]} : w.data;
                    scroll = (scroll & ~MASK_SCROLL) | (scroll_src[9:0] & MASK_SCROLL);
                end
                ADDR_PORT:
                begin
                    port_out = lane_val;
                    if (port_loopback)
                        port_in = lane_val;
                end
                ADDR_SYS:
                begin
                    if (lane_val[SYS_PAGE_SEL_BIT])
                        page = (page & ~MASK_PAGE) | (lane_val & MASK_PAGE);
                    else
                        tape = (tape & ~MASK_TAPE) | (lane_val[12:0] & MASK_TAPE);
                    latch = 1'b1;
                end
                default:
                    r.handled = 1'b0;
            endcase

            // ROM select bits in priority order: 0, 1, 3, 4.
            has_rom = 1'b1;
            rom_sel = 2'd0;
            if (page[0])
                rom_sel = 2'd0;
            else if (page[1])
                rom_sel = 2'd1;
            else if (page[3])
                rom_sel = 2'd2;
            else if (page[4])
                rom_sel = 2'd3;
            else
                has_rom = 1'b0;

            if (has_rom)
            begin
                r.wnd1_page     = ROM_PAGE_FIRST + {2'b00, rom_sel};
                r.wnd1_readable = {{2{rom_present[{rom_sel, 1'b1}]}},
                                   {2{rom_present[{rom_sel, 1'b0}]}}};
            end
            else
            begin
                r.wnd1_page     = {1'b0, phys_page[page[10:8]]};
                r.wnd1_readable = 4'hF;
            end

            r.kbd_int_mask = kbd_mask;
            r.video_ctrl   = video;
            r.screen_page  = video[15] ? SCREEN_PAGE_ALT : SCREEN_PAGE_MAIN;
            r.scroll       = scroll;
            r.port_out     = port_out;
            r.port_in      = port_in;
            r.tape_bits    = tape;
            r.wnd0_page    = phys_page[page[14:12]];
            r.write_latch  = latch;
            reg_view_q.push_back(r);
        endfunction

        function void check_field(string field, logic [15:0] exp_v, logic [15:0] act_v);
            if (act_v !== exp_v)
            begin
                errors++;
                $display("%0t: %s mismatch: expected 0x%04h, actual 0x%04h",
                         $time, field, exp_v, act_v);
            end
        endfunction

        function void check_result(rsp_item_t got);
            rsp_item_t want;
            if (reg_view_q.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected: expected none, actual 0x%h",
                         $time, got);
                return;
            end
            want = reg_view_q.pop_front();
            check_field("handled",       16'(want.handled),       16'(got.handled));
            check_field("kbd_int_mask",  16'(want.kbd_int_mask),  16'(got.kbd_int_mask));
            check_field("video_ctrl",    want.video_ctrl,         got.video_ctrl);
            check_field("screen_page",   16'(want.screen_page),   16'(got.screen_page));
            check_field("scroll",        16'(want.scroll),        16'(got.scroll));
            check_field("port_out",      want.port_out,           got.port_out);
            check_field("port_in",       want.port_in,            got.port_in);
            check_field("tape_bits",     16'(want.tape_bits),     16'(got.tape_bits));
            check_field("wnd0_page",     16'(want.wnd0_page),     16'(got.wnd0_page));
            check_field("wnd1_page",     16'(want.wnd1_page),     16'(got.wnd1_page));
            check_field("wnd1_readable", 16'(want.wnd1_readable), 16'(got.wnd1_readable));
            check_field("write_latch",   16'(want.write_latch),   16'(got.write_latch));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int send_idle_pct;
    int recv_idle_pct;
    int cycle_count;

    sys_reg_scoreboard sb;

    srwpm_wr_if  wr ();
    srwpm_rsp_if rsp ();

    system_register_write_and_page_map i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr.sink),
        .rsp       (rsp.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
        else
            rsp.ready <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && wr.valid && wr.ready)
            sb.note_write({wr.address, wr.data, wr.byte_op});
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
            sb.check_result({rsp.handled, rsp.kbd_int_mask, rsp.video_ctrl,
                             rsp.screen_page, rsp.scroll, rsp.port_out, rsp.port_in,
                             rsp.tape_bits, rsp.wnd0_page, rsp.wnd1_page,
                             rsp.wnd1_readable, rsp.write_latch});
    end

    task automatic send_write(input logic [15:0] address, input logic [15:0] data,
                              input logic byte_op);
        while ($urandom_range(99) < send_idle_pct)
        begin
            wr.valid <= 1'b0;
            @(posedge clk);
        end
        wr.valid   <= 1'b1;
        wr.address <= address;
        wr.data    <= data;
        wr.byte_op <= byte_op;
        @(posedge clk);
        while (!wr.ready)
            @(posedge clk);
    endtask

    // Mostly hits on the five registers with random data, some near misses
    // one address bit away, and some fully random addresses.
    task automatic send_random_write();
        logic [15:0] address;
        logic [15:0] data;
        int          pick;
        pick = $urandom_range(99);
        case ($urandom_range(4))
            0:       address = ADDR_KBD;
            1:       address = ADDR_VIDEO;
            2:       address = ADDR_SCROLL;
            3:       address = ADDR_PORT;
            default: address = ADDR_SYS;
        endcase
        if (pick < 80)
            address[0] = 1'($urandom_range(1));
        else if (pick < 90)
            address = address ^ (16'h0001 << $urandom_range(15, 1));
        else
            address = 16'($urandom_range(16'hFFFF));
        data = 16'($urandom_range(16'hFFFF));
        // Clear the ROM select bits now and then so RAM shows up in window 1.
        if ($urandom_range(2) == 0)
            data = data & ~16'o000033;
        send_write(address, data, 1'($urandom_range(1)));
    endtask

    task automatic wait_for_results();
        wr.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_config(input logic [7:0] rom, input logic loopback);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ROM_PRESENT;
        cfg_wdata <= rom;
        @(posedge clk);
        cfg_index <= CFG_PORT_LOOPBACK;
        cfg_wdata <= {{(CFG_DATA_W - 1){1'b0}}, loopback};
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_config(rom, loopback);
    endtask

    initial
    begin
        logic [7:0] rom;
        logic       loopback;

        sb = new();
        send_idle_pct = 11;
        recv_idle_pct = 59;
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= '0;
        cfg_wdata  <= '0;
        wr.valid   <= 1'b0;
        wr.address <= '0;
        wr.data    <= '0;
        wr.byte_op <= 1'b0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;

        // Mixed ROM population so that the ROM pages see two different bank patterns.
        write_config(8'h5A, 1'b1);

        // Keyboard status: word, low byte, high byte that must not touch it, then a low byte again.
        send_write(ADDR_KBD, 16'hFFFF, 1'b0);
        send_write(ADDR_KBD, 16'h0000, 1'b1);
        send_write(ADDR_KBD | 16'd1, 16'h00FF, 1'b1);
        send_write(ADDR_KBD, 16'h0040, 1'b1);
        // Video control: full word, then byte writes that clear the other lane.
        send_write(ADDR_VIDEO, 16'hFFFF, 1'b0);
        send_write(ADDR_VIDEO | 16'd1, 16'h0080, 1'b1);
        send_write(ADDR_VIDEO, 16'h00FF, 1'b1);
        // Scroll: a byte write at the odd address still fills the low byte.
        send_write(ADDR_SCROLL, 16'hFFFF, 1'b0);
        send_write(ADDR_SCROLL | 16'd1, 16'hFFAB, 1'b1);
        // Parallel port with loopback on.
        send_write(ADDR_PORT, 16'h1234, 1'b0);
        send_write(ADDR_PORT | 16'd1, 16'h00FF, 1'b1);
        // Page register: each ROM select bit, then RAM pages in both windows.
        send_write(ADDR_SYS, 16'h0801, 1'b0);
        send_write(ADDR_SYS, 16'h0802, 1'b0);
        send_write(ADDR_SYS, 16'h0808, 1'b0);
        send_write(ADDR_SYS, 16'h0810, 1'b0);
        send_write(ADDR_SYS, 16'h7F00, 1'b0);
        send_write(ADDR_SYS | 16'd1, 16'h0008, 1'b1);
        // Tape/speaker: a low byte never carries the page select bit.
        send_write(ADDR_SYS, 16'h00FF, 1'b1);
        send_write(ADDR_SYS, 16'hF7FF, 1'b0);
        // Writes that miss every register.
        send_write(16'h0000, 16'hFFFF, 1'b0);
        send_write(16'hFFFF, 16'hFFFF, 1'b1);
        send_write(16'o177666, 16'hFFFF, 1'b0);

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            send_idle_pct = (seg < 2) ? 11 : (seg < 4) ? 59 : 0;
            recv_idle_pct = (seg < 2) ? 59 : (seg < 4) ? 11 : 0;
            case (seg)
                0:
                begin
                    rom      = 8'h00;
                    loopback = 1'b0;
                end
                1:
                begin
                    rom      = 8'hFF;
                    loopback = 1'b1;
                end
                default:
                begin
                    rom      = 8'($urandom_range(255));
                    loopback = seg[0];
                end
            endcase
            // The block goes quiet here before its configuration changes.
            wait_for_results();
            write_config(rom, loopback);
            repeat (WRITES_PER_SEG)
                send_random_write();
        end

        wait_for_results();
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/srwpm_pkg.sv
rtl/srwpm_wr_if.sv
rtl/srwpm_rsp_if.sv
rtl/srwpm_in_stage.sv
rtl/srwpm_sys_regs.sv
rtl/srwpm_page_dec.sv
rtl/system_register_write_and_page_map.sv
verif/tb.sv
